### rtl/fse_pkg.sv
// Shared types and constants for the frame validator.
package fse_pkg;

    localparam logic [31:0] BLOCK_SIZE_RESET = 32'd32768;
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_FRAME   = 2'd0,
        PH_BLOCK   = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_SHORT     = 4'd1,
        ST_MAGIC     = 4'd2,
        ST_BLOCKSIZE = 4'd3,
        ST_TRUNC_HDR = 4'd4,
        ST_MODE      = 4'd5,
        ST_TRUNC_PAY = 4'd6,
        ST_OVERFLOW  = 4'd7,
        ST_MISMATCH  = 4'd8,
        ST_EXTRA     = 4'd9
    } status_t;

    // Classified byte passed from the front end to the parser.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [63:0] frame_length;
        logic [63:0] raw_length;
    } result_t;

endpackage

### rtl/fse_front.sv
// Input stage: accepts bytes into a short queue.
module fse_front
    import fse_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  byte_req_t in_req,
    output logic      q_valid,
    input  logic      q_ready,
    output byte_req_t q_req
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    byte_req_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic push, pop;

    assign in_ready = (count_reg != AW'(0) + (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign q_valid  = count_reg != '0;
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

### rtl/fse_back.sv
// Frame parser: walks the header and block structure one byte per cycle while its result output is not stalled.
module fse_back
    import fse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] expected_block_size,
    input  logic        q_valid,
    output logic        q_ready,
    input  byte_req_t   q_req,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [63:0] shift_reg, shift_next;
    logic [63:0] hraw_reg, hraw_next;
    logic [31:0] blocks_reg, blocks_next;
    logic [31:0] braw_reg, braw_next;
    logic [31:0] pay_reg, pay_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] seen_reg, seen_next;
    logic [3:0]  err_reg, err_next;
    logic        mbad_reg, mbad_next;
    logic        ovf_reg, ovf_next;
    logic        ovalid_reg;
    result_t     res_reg, res_next;
    logic        take;
    logic [7:0]  b;
    logic [31:0] hi;
    logic [3:0]  st;
    logic [64:0] sum_wide;
    logic [3:0]  magic_ch;

    assign q_ready   = !ovalid_reg || out_ready;
    assign take      = q_valid && q_ready;
    assign out_valid = ovalid_reg;
    assign out_res   = res_reg;
    assign b         = q_req.data;

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        hraw_next   = hraw_reg;
        blocks_next = blocks_reg;
        braw_next   = braw_reg;
        pay_next    = pay_reg;
        sum_next    = sum_reg;
        err_next    = err_reg;
        mbad_next   = mbad_reg;
        ovf_next    = ovf_reg;
        seen_next   = (seen_reg != '1) ? seen_reg + 64'd1 : seen_reg;
        shift_next  = {b, shift_reg[63:8]};
        hi          = shift_next[63:32];
        sum_wide    = {1'b0, sum_reg} + {33'd0, braw_reg};
        magic_ch    = 4'd0;
        unique case (idx_reg[1:0])
            2'd0: magic_ch = (b == 8'h4D) ? 4'd1 : 4'd0;
            2'd1: magic_ch = (b == 8'h46) ? 4'd1 : 4'd0;
            2'd2: magic_ch = (b == 8'h53) ? 4'd1 : 4'd0;
            default: magic_ch = (b == 8'h45) ? 4'd1 : 4'd0;
        endcase
        if (err_reg == 4'd0)
        begin
            unique case (phase_reg)
                PH_FRAME:
                begin
                    if (idx_reg < 5'd4 && magic_ch == 4'd0)
                        err_next = ST_MAGIC;
                    else if (idx_reg == 5'd7 && hi != expected_block_size)
                        err_next = ST_BLOCKSIZE;
                    else
                    begin
                        if (idx_reg == 5'd15)
                            hraw_next = shift_next;
                        if (idx_reg == 5'd19)
                        begin
                            blocks_next = hi;
                            idx_next = '0;
                            if (hi == 32'd0)
                            begin
                                if (hraw_reg != 64'd0)
                                    err_next = ST_MISMATCH;
                                else
                                    phase_next = PH_DONE;
                            end
                            else
                                phase_next = PH_BLOCK;
                        end
                        else
                            idx_next = idx_reg + 5'd1;
                    end
                end
                PH_BLOCK:
                begin
                    if (idx_reg == 5'd0)
                        mbad_next = b > 8'd2;
                    if (idx_reg == 5'd4)
                        braw_next = hi;
                    if (idx_reg == 5'd8)
                    begin
                        if (mbad_reg)
                            err_next = ST_MODE;
                        else
                        begin
                            pay_next = hi;
                            ovf_next = sum_wide[64];
                            if (!sum_wide[64])
                                sum_next = sum_wide[63:0];
                            if (hi == 32'd0)
                            begin
                                if (sum_wide[64])
                                    err_next = ST_OVERFLOW;
                                else
                                begin
                                    blocks_next = blocks_reg - 32'd1;
                                    idx_next = '0;
                                    if (blocks_reg == 32'd1)
                                    begin
                                        if (sum_wide[63:0] != hraw_reg)
                                            err_next = ST_MISMATCH;
                                        else
                                            phase_next = PH_DONE;
                                    end
                                end
                            end
                            else
                                phase_next = PH_PAYLOAD;
                        end
                    end
                    else
                        idx_next = idx_reg + 5'd1;
                end
                PH_PAYLOAD:
                begin
                    pay_next = pay_reg - 32'd1;
                    if (pay_reg == 32'd1)
                    begin
                        if (ovf_reg)
                            err_next = ST_OVERFLOW;
                        else
                        begin
                            blocks_next = blocks_reg - 32'd1;
                            idx_next = '0;
                            if (blocks_reg == 32'd1)
                            begin
                                if (sum_reg != hraw_reg)
                                    err_next = ST_MISMATCH;
                                else
                                    phase_next = PH_DONE;
                            end
                            else
                                phase_next = PH_BLOCK;
                        end
                    end
                end
                default: err_next = ST_EXTRA;
            endcase
        end
        if (seen_next < 64'd20)
            st = ST_SHORT;
        else if (err_next != 4'd0)
            st = err_next;
        else if (phase_next == PH_BLOCK)
            st = ST_TRUNC_HDR;
        else if (phase_next == PH_PAYLOAD)
            st = ST_TRUNC_PAY;
        else
            st = ST_OK;
        res_next.status       = st;
        res_next.frame_length = (st == ST_OK) ? seen_next : 64'd0;
        res_next.raw_length   = (st == ST_OK) ? hraw_next : 64'd0;
    end

    always_ff @(posedge clk)
    begin
        if (take && q_req.last)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FRAME; idx_reg <= '0; shift_reg <= '0; hraw_reg <= '0;
            blocks_reg <= '0; braw_reg <= '0; pay_reg <= '0; sum_reg <= '0;
            seen_reg <= '0; err_reg <= '0; mbad_reg <= 1'b0; ovf_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready)
                ovalid_reg <= 1'b0;
            if (take)
            begin
                if (q_req.last)
                begin
                    ovalid_reg <= 1'b1;
                    phase_reg <= PH_FRAME; idx_reg <= '0; shift_reg <= '0;
                    hraw_reg <= '0; blocks_reg <= '0; braw_reg <= '0; pay_reg <= '0;
                    sum_reg <= '0; seen_reg <= '0; err_reg <= '0;
                    mbad_reg <= 1'b0; ovf_reg <= 1'b0;
                end
                else
                begin
                    phase_reg <= phase_next; idx_reg <= idx_next; shift_reg <= shift_next;
                    hraw_reg <= hraw_next; blocks_reg <= blocks_next;
                    braw_reg <= braw_next; pay_reg <= pay_next; sum_reg <= sum_next;
                    seen_reg <= seen_next; err_reg <= err_next;
                    mbad_reg <= mbad_next; ovf_reg <= ovf_next;
                end
            end
        end
    end

endmodule

### rtl/fse_frame_validator_unit.sv
// Top level of the frame validator: config register, input queue and parser.
// The validator takes one frame byte per cycle, back to back, and returns one
// result request on the byte marked last. Bytes enter a two-entry queue and
// the parser consumes one per cycle. The last byte is written into the queue
// memory, the parser then takes it from the queue head and writes the result
// into its output register, which drives m_tvalid. Throughput is one byte per
// cycle while the parser is not stalled. The parser stalls only while a
// finished result waits with m_tready low. During such a stall the queue
// fills, and s_tready then drops until the result is taken. The block size
// register resets to 32768 and should be written only while no frame is in
// flight.
module fse_frame_validator_unit
    import fse_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data,      // expected_block_size
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // data_byte
    input  logic         s_tlast,       // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata        // status[3:0], frame_length[67:4], raw_length[131:68]
);

    logic [31:0] bsize_reg;
    logic        q_valid, q_ready;
    byte_req_t   in_req, q_req;
    result_t     res;

    assign cfg_ready = 1'b1;
    assign in_req.data = s_tdata;
    assign in_req.last = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bsize_reg <= BLOCK_SIZE_RESET;
        else if (cfg_valid)
            bsize_reg <= cfg_data;
    end

    fse_front #(.DEPTH(DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    fse_back u_back (
        .clk(clk), .rst_n(rst_n), .expected_block_size(bsize_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
    );

    assign m_tdata = {4'd0, res.raw_length, res.frame_length, res.status};

endmodule

### rtl/fse_checker.sv
// Port-level checker for the frame validator.
module fse_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= 4'd9)
        else $error("status out of range");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] != 4'd0 |-> m_tdata[131:4] == '0)
        else $error("lengths not zero on error");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3:0] == 4'd0 |-> m_tdata[67:4] >= 64'd20)
        else $error("ok frame shorter than header");

endmodule

bind fse_frame_validator_unit fse_checker u_fse_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
